### design/b32e_pkg.sv
package b32e_pkg;

	localparam int unsigned GroupBytes   = 5;
	localparam int unsigned GroupSymbols = 8;
	localparam logic [6:0]  PadChar      = 7'h3D;

	// one complete (or final partial) group handed from front to back
	typedef struct packed {
		logic [39:0] bits;     // first byte in bits 39..32
		logic [3:0]  nsym;     // data symbols before padding
		logic        eos;      // group ends the stream
	} group_t;

	// data symbols for 1..5 bytes held
	function automatic logic [3:0] data_symbols(input logic [2:0] nbytes);
		logic [3:0] n;
		unique case (nbytes)
			3'd1:    n = 4'd2;
			3'd2:    n = 4'd4;
			3'd3:    n = 4'd5;
			3'd4:    n = 4'd7;
			3'd5:    n = 4'd8;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// base32 alphabet: A-Z then 2-7
	function automatic logic [6:0] alphabet32(input logic [4:0] idx);
		logic [6:0] c;
		if (idx < 5'd26) begin
			c = 7'h41 + {2'b00, idx};
		end else begin
			c = 7'h32 + {2'b00, idx - 5'd26};
		end
		return c;
	endfunction

endpackage

### design/base32_stream_encoder.sv
// Base32 stream encoder (RFC 4648 alphabet and padding).
//
// Slave channel: one byte per transfer on s_tdata, s_tlast marks the last
// byte of the stream. Master channel: one ASCII symbol per transfer on
// m_tdata, m_tuser marks the eighth symbol of a group, m_tlast the eighth
// symbol of the group that closes the stream.
//
// Every five bytes (or fewer when s_tlast arrives) form a group that gives
// eight symbols; a short group is zero-filled and padded with '='.
// The closing byte's group is written into the queue, and its first symbol
// is then registered in the output register. The symbol sequencer gives one
// symbol per cycle while the receiver keeps m_tready high.
// The front takes a byte every cycle while the two-entry group queue has
// room, so it keeps filling the next group while symbols drain.
//
// Reset clears the partial group, the queue and the output valid flag.
// When the receiver stalls the symbol holds in the output register; once
// the queue is full, s_tready stays low for every byte, closing or not,
// until the back releases the group at the queue head.
module base32_stream_encoder
	import b32e_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // end_of_stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] symbol, [7] zero
	output logic       m_tuser,   // [0] group_last
	output logic       m_tlast    // stream_last
);

	logic       push;
	group_t     push_group;
	logic       queue_ready;
	logic       pop;
	logic       head_valid;
	group_t     head_group;
	logic [6:0] symbol;

	// front: pack bytes into groups
	b32e_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.data_byte     (s_tdata),
		.end_of_stream (s_tlast),
		.push          (push),
		.push_group    (push_group),
		.queue_ready   (queue_ready)
	);

	// decouple byte intake from symbol output
	b32e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.push_ready (queue_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_group (head_group)
	);

	// back: walk each group one symbol per transfer
	b32e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_group  (head_group),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.symbol      (symbol),
		.group_last  (m_tuser),
		.stream_last (m_tlast)
	);

	assign m_tdata = {1'b0, symbol};

endmodule

### design/b32e_front.sv
module b32e_front
	import b32e_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	output logic       push,
	output group_t     push_group,
	input  logic       queue_ready
);

	logic [39:0] buf_q;
	logic [2:0]  count_q;
	logic [39:0] merged;
	logic [2:0]  count_next;
	logic        accept;
	logic        done;

	assign in_ready = queue_ready;
	assign accept   = in_valid && queue_ready;

	always_comb begin
		merged = buf_q;
		case (count_q)
			3'd0:    merged[39:32] = data_byte;
			3'd1:    merged[31:24] = data_byte;
			3'd2:    merged[23:16] = data_byte;
			3'd3:    merged[15:8]  = data_byte;
			3'd4:    merged[7:0]   = data_byte;
			default: merged = {data_byte, 32'd0};
		endcase
	end

	assign count_next = (count_q > 3'd4) ? 3'd1 : count_q + 3'd1;
	assign done       = (count_next == 3'(GroupBytes)) || end_of_stream;

	assign push            = accept && done;
	assign push_group.bits = merged;
	assign push_group.nsym = data_symbols(count_next);
	assign push_group.eos  = end_of_stream;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			buf_q   <= '0;
		end else if (accept) begin
			// drop the group once handed over
			if (done) begin
				count_q <= '0;
				buf_q   <= '0;
			end else begin
				count_q <= count_next;
				buf_q   <= merged;
			end
		end
	end

endmodule

### design/b32e_queue.sv
module b32e_queue
	import b32e_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t push_group,
	output logic   push_ready,
	input  logic   pop,
	output logic   head_valid,
	output group_t head_group
);

	group_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_group = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

### design/b32e_back.sv
module b32e_back
	import b32e_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  group_t     head_group,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] symbol,
	output logic       group_last,
	output logic       stream_last
);

	logic [2:0] k_q;
	logic       valid_q;
	logic [6:0] symbol_q;
	logic       group_last_q;
	logic       stream_last_q;
	logic       advance;
	logic       emit;
	logic [4:0] slice [GroupSymbols];
	logic [6:0] sym_next;
	logic       last_sym;

	always_comb begin
		for (int i = 0; i < GroupSymbols; i++) begin
			slice[i] = head_group.bits[39 - 5 * i -: 5];
		end
	end

	assign advance  = !valid_q || out_ready;
	assign emit     = advance && head_valid;
	assign last_sym = (k_q == 3'(GroupSymbols - 1));
	assign pop      = emit && last_sym;
	assign sym_next = ({1'b0, k_q} < head_group.nsym) ? alphabet32(slice[k_q]) : PadChar;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= head_valid;
			if (head_valid) begin
				k_q <= k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			symbol_q      <= sym_next;
			group_last_q  <= last_sym;
			stream_last_q <= last_sym && head_group.eos;
		end
	end

	assign out_valid   = valid_q;
	assign symbol      = symbol_q;
	assign group_last  = group_last_q;
	assign stream_last = stream_last_q;

	// mid-group the entry must still sit at the queue head
	a_mid_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != 3'd0) |-> head_valid)
		else $error("group entry lost mid-group");

	// stream end is only ever flagged on a group end
	a_stream_on_group: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && stream_last_q) |-> group_last_q)
		else $error("stream_last without group_last");

	// releasing the entry wraps the symbol index back to the first symbol
	a_pop_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (k_q == 3'd0))
		else $error("symbol index did not wrap on pop");

	// a new symbol is loaded only when the output slot is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> ($stable(symbol_q) && valid_q))
		else $error("pending symbol overwritten");

endmodule
